>>> src/eafl_pkg.sv
// ----------------------------------------------------------------------------
// eafl_pkg: shared types and constants of the framed link engine
// Line characters, mode, kind and status codes, the controller state
// encodings and the command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package eafl_pkg;

    localparam logic [7:0] CH_ENQ        = 8'h05;
    localparam logic [7:0] CH_ACK        = 8'h06;
    localparam logic [7:0] TIMEOUT_RESET = 8'd20;
    localparam logic [7:0] TIMEOUT_FLOOR = 8'd10;

    localparam logic [2:0] ST_NONE       = 3'd0;
    localparam logic [2:0] ST_SENT       = 3'd1;
    localparam logic [2:0] ST_NO_ACK     = 3'd2;
    localparam logic [2:0] ST_RECEIVED   = 3'd3;
    localparam logic [2:0] ST_RX_TIMEOUT = 3'd4;
    localparam logic [2:0] ST_BAD_SUM    = 3'd5;
    localparam logic [2:0] ST_TOO_LONG   = 3'd6;
    localparam logic [2:0] ST_REFUSED    = 3'd7;

    typedef enum logic [1:0] {
        MODE_TICK  = 2'd0,
        MODE_LINE  = 2'd1,
        MODE_LOAD  = 2'd2,
        MODE_START = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        KIND_LINE    = 2'd0,
        KIND_DELIVER = 2'd1,
        KIND_STATUS  = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_WAIT_ACK,
        PH_RX_LEN,
        PH_RX_DATA,
        PH_RX_SUM
    } phase_t;

    typedef enum logic [2:0] {
        SEQ_ACCEPT,
        SEQ_ENQ,
        SEQ_ACK,
        SEQ_SEND_LEN,
        SEQ_SEND_DATA,
        SEQ_SEND_SUM,
        SEQ_DELIVER,
        SEQ_STATUS
    } seq_t;

    typedef enum logic [2:0] {
        SEL_ZERO,
        SEL_ENQ,
        SEL_ACK,
        SEL_SEND_COUNT,
        SEL_SEND_DATA,
        SEL_RECV_DATA,
        SEL_SEND_PARITY
    } sel_t;

    typedef struct packed {
        logic       accept;
        logic       send_wr;
        logic       send_clr;
        logic       tick_inc;
        logic       tick_clr;
        logic       len_load;
        logic       rx_adv;
        logic       idx_inc;
        logic       push;
        kind_t      push_kind;
        sel_t       push_sel;
        logic [2:0] push_status;
        logic       push_last;
    } ctl_cmd_t;

    typedef struct packed {
        mode_t mode;
        logic  is_enq;
        logic  is_ack;
        logic  expired;
        logic  send_full;
        logic  len_over;
        logic  len_zero;
        logic  rx_done;
        logic  parity_ok;
        logic  send_zero;
        logic  recv_zero;
        logic  send_end;
        logic  recv_end;
        logic  out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

>>> src/eafl_ctrl.sv
// ----------------------------------------------------------------------------
// eafl_ctrl: link controller
// Tracks the link phase, decides on each transaction and sequences the
// results through the datapath output register.
// ----------------------------------------------------------------------------
`default_nettype none

module eafl_ctrl
    import eafl_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_tvalid,
    output logic          s_tready,
    input  wire dp_stat_t stat,
    output ctl_cmd_t      cmd
);

    seq_t       seq_reg, seq_next;
    phase_t     phase_reg, phase_next;
    logic [2:0] code_reg, code_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_reg   <= SEQ_ACCEPT;
            phase_reg <= PH_IDLE;
            code_reg  <= ST_NONE;
        end else begin
            seq_reg   <= seq_next;
            phase_reg <= phase_next;
            code_reg  <= code_next;
        end
    end

    always_comb begin
        seq_next        = seq_reg;
        phase_next      = phase_reg;
        code_next       = code_reg;
        s_tready        = 1'b0;
        cmd             = '0;
        cmd.push_kind   = KIND_LINE;
        cmd.push_sel    = SEL_ZERO;
        cmd.push_status = ST_NONE;
        case (seq_reg)
            SEQ_ACCEPT: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    case (stat.mode)
                        MODE_LOAD, MODE_START: begin
                            if (phase_reg != PH_IDLE) begin
                                code_next = ST_REFUSED;
                                seq_next  = SEQ_STATUS;
                            end else if (stat.mode == MODE_LOAD) begin
                                if (stat.send_full) begin
                                    code_next = ST_TOO_LONG;
                                    seq_next  = SEQ_STATUS;
                                end else begin
                                    cmd.send_wr = 1'b1;
                                end
                            end else begin
                                cmd.tick_clr = 1'b1;
                                phase_next   = PH_WAIT_ACK;
                                seq_next     = SEQ_ENQ;
                            end
                        end
                        MODE_TICK: begin
                            if (phase_reg != PH_IDLE) begin
                                if (stat.expired) begin
                                    code_next    = (phase_reg == PH_WAIT_ACK) ?
                                                   ST_NO_ACK : ST_RX_TIMEOUT;
                                    seq_next     = SEQ_STATUS;
                                    phase_next   = PH_IDLE;
                                    cmd.tick_clr = 1'b1;
                                end else begin
                                    cmd.tick_inc = 1'b1;
                                end
                            end
                        end
                        default: begin
                            case (phase_reg)
                                PH_IDLE: begin
                                    if (stat.is_enq) begin
                                        cmd.tick_clr = 1'b1;
                                        phase_next   = PH_RX_LEN;
                                        seq_next     = SEQ_ACK;
                                    end
                                end
                                PH_WAIT_ACK: begin
                                    if (stat.is_ack) begin
                                        cmd.tick_clr = 1'b1;
                                        phase_next   = PH_IDLE;
                                        seq_next     = SEQ_SEND_LEN;
                                    end
                                end
                                PH_RX_LEN: begin
                                    cmd.tick_clr = 1'b1;
                                    cmd.len_load = 1'b1;
                                    if (stat.len_over) begin
                                        code_next  = ST_TOO_LONG;
                                        seq_next   = SEQ_STATUS;
                                        phase_next = PH_IDLE;
                                    end else if (stat.len_zero) begin
                                        phase_next = PH_RX_SUM;
                                    end else begin
                                        phase_next = PH_RX_DATA;
                                    end
                                end
                                PH_RX_DATA: begin
                                    cmd.tick_clr = 1'b1;
                                    cmd.rx_adv   = 1'b1;
                                    if (stat.rx_done) begin
                                        phase_next = PH_RX_SUM;
                                    end
                                end
                                default: begin
                                    cmd.tick_clr = 1'b1;
                                    phase_next   = PH_IDLE;
                                    if (stat.parity_ok) begin
                                        code_next = ST_RECEIVED;
                                        seq_next  = stat.recv_zero ? SEQ_STATUS : SEQ_DELIVER;
                                    end else begin
                                        code_next = ST_BAD_SUM;
                                        seq_next  = SEQ_STATUS;
                                    end
                                end
                            endcase
                        end
                    endcase
                end
            end
            SEQ_ENQ: begin
                if (stat.out_free) begin
                    cmd.push      = 1'b1;
                    cmd.push_sel  = SEL_ENQ;
                    cmd.push_last = 1'b1;
                    seq_next      = SEQ_ACCEPT;
                end
            end
            SEQ_ACK: begin
                if (stat.out_free) begin
                    cmd.push      = 1'b1;
                    cmd.push_sel  = SEL_ACK;
                    cmd.push_last = 1'b1;
                    seq_next      = SEQ_ACCEPT;
                end
            end
            SEQ_SEND_LEN: begin
                if (stat.out_free) begin
                    cmd.push     = 1'b1;
                    cmd.push_sel = SEL_SEND_COUNT;
                    seq_next     = stat.send_zero ? SEQ_SEND_SUM : SEQ_SEND_DATA;
                end
            end
            SEQ_SEND_DATA: begin
                if (stat.out_free) begin
                    cmd.push     = 1'b1;
                    cmd.push_sel = SEL_SEND_DATA;
                    cmd.idx_inc  = 1'b1;
                    if (stat.send_end) begin
                        seq_next = SEQ_SEND_SUM;
                    end
                end
            end
            SEQ_SEND_SUM: begin
                if (stat.out_free) begin
                    cmd.push     = 1'b1;
                    cmd.push_sel = SEL_SEND_PARITY;
                    cmd.send_clr = 1'b1;
                    code_next    = ST_SENT;
                    seq_next     = SEQ_STATUS;
                end
            end
            SEQ_DELIVER: begin
                if (stat.out_free) begin
                    cmd.push      = 1'b1;
                    cmd.push_kind = KIND_DELIVER;
                    cmd.push_sel  = SEL_RECV_DATA;
                    cmd.idx_inc   = 1'b1;
                    if (stat.recv_end) begin
                        seq_next = SEQ_STATUS;
                    end
                end
            end
            SEQ_STATUS: begin
                if (stat.out_free) begin
                    cmd.push        = 1'b1;
                    cmd.push_kind   = KIND_STATUS;
                    cmd.push_status = code_reg;
                    cmd.push_last   = 1'b1;
                    seq_next        = SEQ_ACCEPT;
                end
            end
            default: begin
                seq_next = SEQ_ACCEPT;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> src/eafl_dp.sv
// ----------------------------------------------------------------------------
// eafl_dp: link datapath
// Timeout counter, send and receive payload memories, counts and checksums,
// and the result output register.
// ----------------------------------------------------------------------------
`default_nettype none

module eafl_dp
    import eafl_pkg::*;
#(
    parameter int PAYLOAD_MAX = 32
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       cfg_wr_en,
    input  wire logic [7:0] cfg_wr_data,
    input  wire logic [7:0] s_tdata,
    input  wire logic [1:0] s_tuser,
    input  wire ctl_cmd_t   cmd,
    output dp_stat_t        stat,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [15:0]     m_tdata,
    output logic [1:0]      m_tuser,
    output logic            m_tlast
);

    localparam int CW = $clog2(PAYLOAD_MAX + 1);
    localparam int AW = (PAYLOAD_MAX > 1) ? $clog2(PAYLOAD_MAX) : 1;

    logic [7:0]    send_mem [PAYLOAD_MAX];
    logic [7:0]    recv_mem [PAYLOAD_MAX];

    logic [7:0]    timeout_reg;
    logic [7:0]    elapsed_reg;
    logic [CW-1:0] send_count_reg;
    logic [7:0]    send_par_reg;
    logic [CW-1:0] recv_len_reg;
    logic [CW-1:0] recv_count_reg;
    logic [7:0]    recv_par_reg;
    logic [CW-1:0] idx_reg, idx_next;
    logic [7:0]    send_rd_reg;
    logic [7:0]    recv_rd_reg;
    logic          valid_reg;
    logic [7:0]    byte_reg;
    logic [2:0]    status_reg;
    logic [1:0]    kind_reg;
    logic          last_reg;

    logic [CW-1:0] idx_inc_v;
    logic [CW-1:0] recv_count_inc;
    logic [7:0]    push_byte;

    assign idx_inc_v      = idx_reg + CW'(1);
    assign recv_count_inc = recv_count_reg + CW'(1);

    always_comb begin
        if (cmd.accept) begin
            idx_next = '0;
        end else if (cmd.idx_inc) begin
            idx_next = idx_inc_v;
        end else begin
            idx_next = idx_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.send_wr) begin
            send_mem[send_count_reg[AW-1:0]] <= s_tdata;
        end
        send_rd_reg <= send_mem[idx_next[AW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (cmd.rx_adv) begin
            recv_mem[recv_count_reg[AW-1:0]] <= s_tdata;
        end
        recv_rd_reg <= recv_mem[idx_next[AW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg    <= TIMEOUT_RESET;
            elapsed_reg    <= '0;
            send_count_reg <= '0;
            send_par_reg   <= '0;
            recv_len_reg   <= '0;
            recv_count_reg <= '0;
            recv_par_reg   <= '0;
            idx_reg        <= '0;
            valid_reg      <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                timeout_reg <= (cfg_wr_data < TIMEOUT_FLOOR) ? TIMEOUT_FLOOR : cfg_wr_data;
            end
            if (cmd.tick_clr) begin
                elapsed_reg <= '0;
            end else if (cmd.tick_inc) begin
                elapsed_reg <= elapsed_reg + 8'd1;
            end
            if (cmd.send_clr) begin
                send_count_reg <= '0;
                send_par_reg   <= '0;
            end else if (cmd.send_wr) begin
                send_count_reg <= send_count_reg + CW'(1);
                send_par_reg   <= send_par_reg ^ s_tdata;
            end
            if (cmd.len_load) begin
                recv_len_reg   <= s_tdata[CW-1:0];
                recv_count_reg <= '0;
                recv_par_reg   <= '0;
            end else if (cmd.rx_adv) begin
                recv_count_reg <= recv_count_inc;
                recv_par_reg   <= recv_par_reg ^ s_tdata;
            end
            idx_reg <= idx_next;
            if (cmd.push) begin
                valid_reg <= 1'b1;
            end else if (m_tready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_comb begin
        case (cmd.push_sel)
            SEL_ENQ:         push_byte = CH_ENQ;
            SEL_ACK:         push_byte = CH_ACK;
            SEL_SEND_COUNT:  push_byte = 8'(send_count_reg);
            SEL_SEND_DATA:   push_byte = send_rd_reg;
            SEL_RECV_DATA:   push_byte = recv_rd_reg;
            SEL_SEND_PARITY: push_byte = send_par_reg;
            default:         push_byte = 8'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            byte_reg   <= push_byte;
            status_reg <= cmd.push_status;
            kind_reg   <= cmd.push_kind;
            last_reg   <= cmd.push_last;
        end
    end

    assign stat.mode      = mode_t'(s_tuser);
    assign stat.is_enq    = (s_tdata == CH_ENQ);
    assign stat.is_ack    = (s_tdata == CH_ACK);
    assign stat.expired   = (elapsed_reg >= timeout_reg);
    assign stat.send_full = (send_count_reg >= CW'(PAYLOAD_MAX));
    assign stat.len_over  = (s_tdata > 8'(PAYLOAD_MAX));
    assign stat.len_zero  = (s_tdata == 8'd0);
    assign stat.rx_done   = (recv_count_inc >= recv_len_reg);
    assign stat.parity_ok = (s_tdata == recv_par_reg);
    assign stat.send_zero = (send_count_reg == '0);
    assign stat.recv_zero = (recv_count_reg == '0);
    assign stat.send_end  = (idx_inc_v == send_count_reg);
    assign stat.recv_end  = (idx_inc_v == recv_count_reg);
    assign stat.out_free  = !valid_reg || m_tready;

    assign m_tvalid = valid_reg;
    assign m_tdata  = {5'd0, status_reg, byte_reg};
    assign m_tuser  = kind_reg;
    assign m_tlast  = last_reg;

endmodule

`default_nettype wire

>>> src/enq_ack_framed_link.sv
// ----------------------------------------------------------------------------
// enq_ack_framed_link: ENQ/ACK handshake link with length framing and XOR sum
// Half-duplex byte link engine: sends a queued payload after an ENQ/ACK
// handshake, receives length-framed payloads and releases them on a good sum.
// ----------------------------------------------------------------------------
// Each input transaction (tick, line byte, payload load or start) is accepted by
// the controller; the engine then puts its results out through a single output
// register at one per cycle while m_tready stays high, and takes the next
// transaction once the last result is loaded. The payload memories have no
// reset and need no clearing pass.
`default_nettype none

module enq_ack_framed_link
    import eafl_pkg::*;
#(
    parameter int PAYLOAD_MAX = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [7:0]  cfg_wr_data,   // timeout_ms
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,       // [7:0] data_byte
    input  wire logic [1:0]  s_tuser,       // [1:0] mode
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,       // [7:0] out_byte, [10:8] status
    output logic [1:0]       m_tuser,       // [1:0] kind
    output logic             m_tlast        // last_of_run
);

    ctl_cmd_t cmd;
    dp_stat_t stat;

    eafl_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    eafl_dp #(
        .PAYLOAD_MAX (PAYLOAD_MAX)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .cmd         (cmd),
        .stat        (stat),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

endmodule

`default_nettype wire

>>> src/eafl_chk.sv
// ----------------------------------------------------------------------------
// eafl_chk: port checker for the framed link engine
// Watches the top-level ports for output protocol and result coding rules.
// ----------------------------------------------------------------------------
`default_nettype none

module eafl_chk
    import eafl_pkg::*;
(
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        cfg_wr_en,
    input wire logic [7:0]  cfg_wr_data,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [7:0]  s_tdata,
    input wire logic [1:0]  s_tuser,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata,
    input wire logic [1:0]  m_tuser,
    input wire logic        m_tlast
);

    a_valid_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("m_tvalid dropped while stalled");

    a_data_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
        else $error("result changed while stalled");

    a_status_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_STATUS |-> m_tlast && m_tdata[7:0] == 8'd0
                                               && m_tdata[10:8] != ST_NONE)
        else $error("status transaction badly coded");

    a_data_no_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != KIND_STATUS |-> m_tdata[10:8] == ST_NONE
                                               && m_tuser != 2'd3)
        else $error("byte transaction carries a status");

    a_delivery_tail: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tuser == KIND_DELIVER |=>
            !m_tvalid || m_tuser == KIND_DELIVER || m_tuser == KIND_STATUS)
        else $error("delivery not followed by more payload or status");

endmodule

bind enq_ack_framed_link eafl_chk u_eafl_chk (.*);

`default_nettype wire
